// ===== rtl/core/dbp_pkg.sv =====
package dbp_pkg;

   localparam int DbpFifoDepth = 4;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_BASE  = 1'b1
   } dbp_cmd_type;

   localparam logic [7:0] CodeMask2 = 8'h03;
   localparam logic [7:0] CodeMask4 = 8'h0F;
   localparam logic [1:0] LastSlot2 = 2'd3;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } dbp_result_type;

   typedef struct packed {
      logic [1:0]     count;
      dbp_result_type first;
      dbp_result_type second;
   } dbp_push_type;

   function automatic logic [7:0] dbp_base_code(input logic [7:0] ch, input logic with_n);
      logic [7:0] code;
      begin
         case (ch)
            8'h41: code = 8'd0;
            8'h47: code = 8'd1;
            8'h43: code = 8'd2;
            8'h54: code = 8'd3;
            8'h4E: code = with_n ? 8'd4 : 8'd0;
            default: code = 8'd0;
         endcase
         return code;
      end
   endfunction

endpackage

// ===== rtl/core/dbp_if.sv =====
interface dbp_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [15:0] read_length;
   logic [7:0]  base_char;

   modport source (output valid, command, read_length, base_char, input ready);
   modport sink (input valid, command, read_length, base_char, output ready);
endinterface

interface dbp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, out_byte, last, input ready);
   modport sink (input valid, out_byte, last, output ready);
endinterface

interface dbp_csr_if;
   logic valid;
   logic ready;
   logic nibble_mode;

   modport source (output valid, nibble_mode, input ready);
   modport sink (input valid, nibble_mode, output ready);
endinterface

// ===== rtl/core/dbp_fifo.sv =====
module dbp_fifo
   import dbp_pkg::*;
#(
   parameter int DEPTH = DbpFifoDepth
) (
   input  logic           clock,
   input  logic           reset,
   input  dbp_push_type   push,
   output logic           room_for_two,
   output logic           out_valid,
   input  logic           out_ready,
   output dbp_result_type out_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PtrMax = PW'(DEPTH - 1);
   localparam logic [CW-1:0] RoomLimit = CW'(DEPTH - 2);

   dbp_result_type entry_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_ptr_1;
   logic [CW-1:0]  count_ff, count_in;
   logic           pop;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (p == PtrMax) ? '0 : p + PW'(1);
   endfunction

   assign pop          = out_valid && out_ready;
   assign out_valid    = (count_ff != '0);
   assign out_data     = entry_ff[rd_ptr_ff];
   assign room_for_two = (count_ff <= RoomLimit);
   assign wr_ptr_1     = bump(wr_ptr_ff);

   always_comb begin
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      case (push.count)
         2'd1: wr_ptr_in = wr_ptr_1;
         2'd2: wr_ptr_in = bump(wr_ptr_1);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      count_in = count_ff + CW'(push.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_1] <= push.second;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count beyond depth");
   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room_for_two)
      else $error("push without room");
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (pop && push.count == 2'd0) |=> count_ff == $past(count_ff) - CW'(1))
      else $error("pop did not lower count");
`endif

endmodule

// ===== rtl/core/dna_base_packer.sv =====
// latency: a transfer's results can be taken from the cycle after its acceptance
// throughput: one item per cycle; a start item yields two bytes, a base at most one
// a four-entry result queue sets the rate: items are taken while it has room for two
// reset: synchronous, clears mode, accumulator, slot, bases left and the queue
module dna_base_packer
   import dbp_pkg::*;
#(
   parameter int FIFO_DEPTH = DbpFifoDepth
) (
   input  logic   clock,
   input  logic   reset,
   dbp_req_if.sink   req_ch,
   dbp_rsp_if.source rsp_ch,
   dbp_csr_if.sink   csr_ch
);

   logic         mode_ff, mode_in;
   logic [7:0]   acc_ff, acc_in;
   logic [1:0]   slot_ff, slot_in;
   logic [15:0]  left_ff, left_in;
   logic         room_for_two, req_xfer;
   dbp_push_type push;
   dbp_result_type head;
   logic [7:0]   code, shifted, merged;
   logic [15:0]  left_dec;
   logic         full;

   assign req_ch.ready = room_for_two;
   assign csr_ch.ready = 1'b1;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   always_comb begin
      if (mode_ff) begin
         code    = dbp_base_code(req_ch.base_char, 1'b1) & CodeMask4;
         shifted = slot_ff[0] ? (code << 4) : code;
         full    = (slot_ff != 2'd0);
      end else begin
         code    = dbp_base_code(req_ch.base_char, 1'b0) & CodeMask2;
         shifted = code << {slot_ff, 1'b0};
         full    = (slot_ff == LastSlot2);
      end
      merged   = acc_ff | shifted;
      left_dec = left_ff - 16'd1;
   end

   always_comb begin
      mode_in = (csr_ch.valid && csr_ch.ready) ? csr_ch.nibble_mode : mode_ff;
      acc_in  = acc_ff;
      slot_in = slot_ff;
      left_in = left_ff;
      push    = '0;
      if (req_xfer) begin
         if (dbp_cmd_type'(req_ch.command) == CMD_START) begin
            left_in               = req_ch.read_length;
            acc_in                = '0;
            slot_in               = '0;
            push.count            = 2'd2;
            push.first.out_byte   = req_ch.read_length[7:0];
            push.first.last       = 1'b0;
            push.second.out_byte  = req_ch.read_length[15:8];
            push.second.last      = (req_ch.read_length == 16'd0);
         end else if (left_ff != 16'd0) begin
            left_in = left_dec;
            if (full || left_dec == 16'd0) begin
               push.count          = 2'd1;
               push.first.out_byte = merged;
               push.first.last     = (left_dec == 16'd0);
               acc_in              = '0;
               slot_in             = '0;
            end else begin
               acc_in  = merged;
               slot_in = slot_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         acc_ff  <= '0;
         slot_ff <= '0;
         left_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         slot_ff <= slot_in;
         left_ff <= left_in;
      end
   end

   dbp_fifo #(
      .DEPTH(FIFO_DEPTH)
   ) u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .room_for_two(room_for_two),
      .out_valid   (rsp_ch.valid),
      .out_ready   (rsp_ch.ready),
      .out_data    (head)
   );

   assign rsp_ch.out_byte = head.out_byte;
   assign rsp_ch.last     = head.last;

`ifndef SYNTHESIS
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_ch.command == CMD_START) |=>
         (acc_ff == 8'd0 && slot_ff == 2'd0 && left_ff == $past(req_ch.read_length)))
      else $error("start transfer did not reset packing state");
   a_idle_base: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_ch.command == CMD_BASE && left_ff == 16'd0) |=>
         (left_ff == 16'd0 && $stable(acc_ff) && $stable(slot_ff)))
      else $error("base beyond read length changed state");
   a_empty_slot: assert property (@(posedge clock) disable iff (reset)
      (left_ff == 16'd0) |-> (acc_ff == 8'd0 && slot_ff == 2'd0))
      else $error("partial byte left after read end");
`endif

endmodule

// ===== bench/tb.sv =====
module tb;
   import dbp_pkg::*;

   localparam int ItemTarget   = 1850;
   localparam int CalmTail     = 150;
   localparam int SettleCycles = 4;
   localparam int StallLimit   = 2000;

   localparam logic [7:0] ChA = "A";
   localparam logic [7:0] ChG = "G";
   localparam logic [7:0] ChC = "C";
   localparam logic [7:0] ChT = "T";
   localparam logic [7:0] ChN = "N";

   typedef enum logic {
      ROW_ITEM = 1'b0,
      ROW_CSR  = 1'b1
   } row_kind_type;

   typedef struct {
      row_kind_type   kind;
      logic           mode;
      dbp_cmd_type    cmd;
      logic [15:0]    len;
      logic [7:0]     ch;
      int             typed;
      dbp_result_type t0;
      dbp_result_type t1;
   } stim_row_type;

   logic clock;
   logic reset;

   dbp_req_if req_ch ();
   dbp_rsp_if rsp_ch ();
   dbp_csr_if csr_ch ();

   dna_base_packer u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // packing state kept alongside the block
   logic        nib_mode  = 1'b0;
   logic [7:0]  acc_byte  = 8'h00;
   logic [1:0]  slot_pos  = 2'd0;
   logic [15:0] bases_rem = 16'd0;

   dbp_result_type packed_bytes_q[$];
   stim_row_type   dir_rows[$];
   int             err_count   = 0;
   int             idle_cycles = 0;
   logic           idle_on     = 1'b1;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [7:0] symbol_code(input logic [7:0] ch, input logic with_n);
      case (ch)
         ChA: return 8'd0;
         ChG: return 8'd1;
         ChC: return 8'd2;
         ChT: return 8'd3;
         ChN: return with_n ? 8'd4 : 8'd0;
         default: return 8'd0;
      endcase
   endfunction

   function automatic int pack_predict(input dbp_cmd_type cmd, input logic [15:0] len,
                                       input logic [7:0] ch, output dbp_result_type r0,
                                       output dbp_result_type r1);
      logic [7:0] code;
      logic       full;
      r0 = '0;
      r1 = '0;
      if (cmd == CMD_START) begin
         bases_rem   = len;
         acc_byte    = 8'h00;
         slot_pos    = 2'd0;
         r0.out_byte = len[7:0];
         r0.last     = 1'b0;
         r1.out_byte = len[15:8];
         r1.last     = (len == 16'd0);
         return 2;
      end
      if (bases_rem == 16'd0) return 0;
      if (nib_mode) begin
         code     = symbol_code(ch, 1'b1) & CodeMask4;
         acc_byte = acc_byte | (slot_pos[0] ? (code << 4) : code);
         full     = (slot_pos != 2'd0);
      end else begin
         code     = symbol_code(ch, 1'b0) & CodeMask2;
         acc_byte = acc_byte | (code << {slot_pos, 1'b0});
         full     = (slot_pos == LastSlot2);
      end
      bases_rem = bases_rem - 16'd1;
      if (full || bases_rem == 16'd0) begin
         r0.out_byte = acc_byte;
         r0.last     = (bases_rem == 16'd0);
         acc_byte    = 8'h00;
         slot_pos    = 2'd0;
         return 1;
      end
      slot_pos = slot_pos + 2'd1;
      return 0;
   endfunction

   function automatic logic [7:0] pick_char();
      logic [7:0] bases[5];
      logic [7:0] lower[5];
      int         r;
      bases = '{ChA, ChG, ChC, ChT, ChN};
      lower = '{"a", "g", "c", "t", "n"};
      r = $urandom_range(0, 15);
      if (r < 10) return bases[$urandom_range(0, (r < 8) ? 3 : 4)];
      if (r < 12) return lower[$urandom_range(0, 4)];
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic add_item(input dbp_cmd_type cmd, input logic [15:0] len, input logic [7:0] ch,
                           input int typed, input dbp_result_type t0, input dbp_result_type t1);
      stim_row_type row;
      row.kind  = ROW_ITEM;
      row.mode  = 1'b0;
      row.cmd   = cmd;
      row.len   = len;
      row.ch    = ch;
      row.typed = typed;
      row.t0    = t0;
      row.t1    = t1;
      dir_rows.push_back(row);
   endtask

   task automatic add_csr(input logic mode);
      stim_row_type row;
      row.kind  = ROW_CSR;
      row.mode  = mode;
      row.cmd   = CMD_START;
      row.len   = 16'd0;
      row.ch    = 8'h00;
      row.typed = 0;
      row.t0    = '0;
      row.t1    = '0;
      dir_rows.push_back(row);
   endtask

   // entered and left at a falling edge
   task automatic send_req(input dbp_cmd_type cmd, input logic [15:0] len, input logic [7:0] ch,
                           input int typed, input dbp_result_type t0, input dbp_result_type t1);
      dbp_result_type r0, r1;
      int             n;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_ch.valid       = 1'b1;
      req_ch.command     = cmd;
      req_ch.read_length = len;
      req_ch.base_char   = ch;
      do @(posedge clock); while (!req_ch.ready);
      n = pack_predict(cmd, len, ch, r0, r1);
      if (typed > 0) begin
         packed_bytes_q.push_back(t0);
         if (typed > 1) packed_bytes_q.push_back(t1);
      end else begin
         if (n > 0) packed_bytes_q.push_back(r0);
         if (n > 1) packed_bytes_q.push_back(r1);
      end
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_ch.valid = 1'b0;
      while (packed_bytes_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic mode);
      csr_ch.valid       = 1'b1;
      csr_ch.nibble_mode = mode;
      do @(posedge clock); while (!csr_ch.ready);
      nib_mode = mode;
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   initial begin
      rsp_ch.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
            rsp_ch.ready = 1'b1;
         end
      end
   end

   // compare each transfer on the result side and watch for a stall
   always @(posedge clock) begin : rsp_check
      dbp_result_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (packed_bytes_q.size() == 0) begin
               err_count++;
               $display("%0t: unexpected transfer, expected none, actual byte %02h last %0b",
                        $time, rsp_ch.out_byte, rsp_ch.last);
            end else begin
               want = packed_bytes_q.pop_front();
               if (rsp_ch.out_byte !== want.out_byte) begin
                  err_count++;
                  $display("%0t: out_byte expected %02h actual %02h",
                           $time, want.out_byte, rsp_ch.out_byte);
               end
               if (rsp_ch.last !== want.last) begin
                  err_count++;
                  $display("%0t: last expected %0b actual %0b", $time, want.last, rsp_ch.last);
               end
            end
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : watchdog
      wait (idle_cycles >= StallLimit);
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      int          work_done;
      int          nb;
      int          extra;
      int          mid;
      int          r;
      logic [15:0] len;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.command     = CMD_START;
      req_ch.read_length = 16'd0;
      req_ch.base_char   = 8'h00;
      csr_ch.valid       = 1'b0;
      csr_ch.nibble_mode = 1'b0;

      // directed table
      add_item(CMD_START, 16'd0, 8'h00, 2, {8'h00, 1'b0}, {8'h00, 1'b1});
      add_csr(1'b0);
      add_item(CMD_START, 16'd5, 8'h00, 2, {8'h05, 1'b0}, {8'h00, 1'b0});
      add_item(CMD_BASE, 16'd0, ChA, 0, '0, '0);
      add_item(CMD_BASE, 16'd0, ChG, 0, '0, '0);
      add_item(CMD_BASE, 16'd0, ChC, 0, '0, '0);
      add_item(CMD_BASE, 16'd0, ChT, 0, '0, '0);
      add_item(CMD_BASE, 16'hFFFF, ChN, 0, '0, '0);
      // no bases left
      add_item(CMD_BASE, 16'd0, ChA, 0, '0, '0);
      add_csr(1'b1);
      add_item(CMD_START, 16'hFFFF, 8'hFF, 2, {8'hFF, 1'b0}, {8'hFF, 1'b0});
      add_item(CMD_BASE, 16'd0, ChN, 0, '0, '0);
      add_item(CMD_BASE, 16'd0, ChT, 0, '0, '0);
      add_item(CMD_BASE, 16'd0, "a", 0, '0, '0);
      add_item(CMD_BASE, 16'd0, 8'hFF, 0, '0, '0);
      // restart abandons the open read
      add_item(CMD_START, 16'h0100, 8'h00, 2, {8'h00, 1'b0}, {8'h01, 1'b0});
      add_item(CMD_BASE, 16'd0, ChC, 0, '0, '0);
      add_csr(1'b0);
      add_item(CMD_BASE, 16'd0, ChG, 0, '0, '0);
      add_item(CMD_BASE, 16'd0, ChT, 0, '0, '0);
      add_item(CMD_BASE, 16'd0, ChA, 0, '0, '0);
      add_item(CMD_START, 16'd4, 8'h00, 2, {8'h04, 1'b0}, {8'h00, 1'b0});
      add_item(CMD_BASE, 16'd0, ChA, 0, '0, '0);
      add_item(CMD_BASE, 16'd0, ChG, 0, '0, '0);
      add_csr(1'b1);
      add_item(CMD_BASE, 16'd0, ChN, 0, '0, '0);
      add_item(CMD_BASE, 16'd0, 8'h00, 0, '0, '0);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            drain_results();
            write_csr(dir_rows[i].mode);
         end else begin
            send_req(dir_rows[i].cmd, dir_rows[i].len, dir_rows[i].ch, dir_rows[i].typed,
                     dir_rows[i].t0, dir_rows[i].t1);
         end
      end

      work_done = 0;
      while (work_done < ItemTarget) begin
         if (work_done > ItemTarget - CalmTail) idle_on = 1'b0;
         if (idle_on && $urandom_range(0, 5) == 0) begin
            drain_results();
            write_csr(1'($urandom_range(0, 1)));
         end
         r = $urandom_range(0, 19);
         if (r == 0) len = 16'd0;
         else if (r < 15) len = 16'($urandom_range(1, 12));
         else if (r < 18) len = 16'($urandom_range(13, 64));
         else len = 16'($urandom_range(0, 65535));
         send_req(CMD_START, len, 8'($urandom_range(0, 255)), 0, '0, '0);
         work_done++;
         extra = 0;
         if (len <= 16'd64) begin
            nb = int'(len);
            r = $urandom_range(0, 9);
            if (r == 0) nb = $urandom_range(0, len);
            else if (r == 1) extra = $urandom_range(1, 3);
         end else begin
            nb = $urandom_range(0, 24);
         end
         mid = (idle_on && nb > 1 && $urandom_range(0, 7) == 0) ?
               $urandom_range(1, nb - 1) : -1;
         for (int i = 0; i < nb; i++) begin
            if (i == mid) begin
               // mode flip inside an open read
               drain_results();
               write_csr(~nib_mode);
            end
            send_req(CMD_BASE, 16'($urandom_range(0, 65535)), pick_char(), 0, '0, '0);
            work_done++;
         end
         for (int i = 0; i < extra; i++)
            send_req(CMD_BASE, 16'($urandom_range(0, 65535)), pick_char(), 0, '0, '0);
      end

      req_ch.valid = 1'b0;
      while (packed_bytes_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (err_count == 0 && packed_bytes_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
